>>> hw/rtl/drmt_pkg.sv
// Shared types and constants for the damage rectangle merge and trim block.
package drmt_pkg;

    localparam int COORD_BITS   = 13;
    localparam int OUTPOS_BITS  = COORD_BITS + 1;
    localparam int IN_POS_BITS  = 12;
    localparam int PIXEL_BITS   = 32;
    localparam int OP_BITS      = 2;

    localparam int S_TDATA_BITS = 120;
    localparam int M_TDATA_BITS = 56;

    localparam logic [OP_BITS-1:0] OP_REPORT = 2'd0;
    localparam logic [OP_BITS-1:0] OP_PIXEL  = 2'd1;
    localparam logic [OP_BITS-1:0] OP_FINISH = 2'd2;
    localparam logic [OP_BITS-1:0] OP_NONE   = 2'd3;

    localparam logic KIND_NOTICE  = 1'b0;
    localparam logic KIND_REFRESH = 1'b1;

    localparam logic CFG_SCREEN_W = 1'b0;
    localparam logic CFG_SCREEN_H = 1'b1;

    localparam logic [COORD_BITS-1:0] SCREEN_W_RESET = 13'd1024;
    localparam logic [COORD_BITS-1:0] SCREEN_H_RESET = 13'd768;

    localparam int Q_DEPTH    = 4;
    localparam int Q_PTR_BITS = $clog2(Q_DEPTH);
    localparam int Q_CNT_BITS = $clog2(Q_DEPTH + 1);

    // Classified request as it travels from front to back
    typedef struct packed {
        logic [OP_BITS-1:0]     op;
        logic [IN_POS_BITS-1:0] pos_x;
        logic [IN_POS_BITS-1:0] pos_y;
        logic [COORD_BITS-1:0]  rect_width;
        logic [COORD_BITS-1:0]  rect_height;
        logic [OUTPOS_BITS-1:0] rep_end_x;
        logic [OUTPOS_BITS-1:0] rep_end_y;
        logic                   differ;
    } t_item;

    typedef struct packed {
        logic                   kind;
        logic [OUTPOS_BITS-1:0] out_x;
        logic [OUTPOS_BITS-1:0] out_y;
        logic [COORD_BITS-1:0]  out_width;
        logic [COORD_BITS-1:0]  out_height;
    } t_result;

endpackage

>>> hw/rtl/drmt_front.sv
// Input stage: takes requests, drops unused op codes, precomputes report ends and pixel compare.
module drmt_front (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_valid,
    output logic                                 o_ready,
    input  logic [drmt_pkg::OP_BITS-1:0]         i_op,
    input  logic [drmt_pkg::IN_POS_BITS-1:0]     i_pos_x,
    input  logic [drmt_pkg::IN_POS_BITS-1:0]     i_pos_y,
    input  logic [drmt_pkg::COORD_BITS-1:0]      i_rect_width,
    input  logic [drmt_pkg::COORD_BITS-1:0]      i_rect_height,
    input  logic [drmt_pkg::PIXEL_BITS-1:0]      i_old_pixel,
    input  logic [drmt_pkg::PIXEL_BITS-1:0]      i_new_pixel,
    output logic                                 o_push,
    input  logic                                 i_q_ready,
    output drmt_pkg::t_item                      o_item
);

    logic            r_valid;
    drmt_pkg::t_item r_item;
    drmt_pkg::t_item n_item;
    logic            accept;

    assign o_ready = !r_valid || i_q_ready;
    assign accept  = i_valid && o_ready;
    assign o_push  = r_valid && i_q_ready;
    assign o_item  = r_item;

    always_comb begin
        n_item.op          = i_op;
        n_item.pos_x       = i_pos_x;
        n_item.pos_y       = i_pos_y;
        n_item.rect_width  = i_rect_width;
        n_item.rect_height = i_rect_height;
        n_item.rep_end_x   = drmt_pkg::OUTPOS_BITS'(i_pos_x)
                           + drmt_pkg::OUTPOS_BITS'(i_rect_width);
        n_item.rep_end_y   = drmt_pkg::OUTPOS_BITS'(i_pos_y)
                           + drmt_pkg::OUTPOS_BITS'(i_rect_height);
        n_item.differ      = i_old_pixel != i_new_pixel;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (accept) begin
            // unused op code has no effect, so it never enters the queue
            r_valid <= i_op != drmt_pkg::OP_NONE;
        end else if (o_push) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_item <= n_item;
        end
    end

endmodule

>>> hw/rtl/drmt_queue.sv
// Small FIFO between the front stage and the rectangle engine.
module drmt_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    output logic            o_ready,
    input  drmt_pkg::t_item i_item,
    output logic            o_valid,
    input  logic            i_pop,
    output drmt_pkg::t_item o_item
);

    drmt_pkg::t_item                     r_mem [drmt_pkg::Q_DEPTH];
    logic [drmt_pkg::Q_PTR_BITS-1:0]     r_wr_ptr;
    logic [drmt_pkg::Q_PTR_BITS-1:0]     r_rd_ptr;
    logic [drmt_pkg::Q_CNT_BITS-1:0]     r_count;
    logic                                do_push;
    logic                                do_pop;

    assign o_ready = r_count != drmt_pkg::Q_CNT_BITS'(drmt_pkg::Q_DEPTH);
    assign o_valid = r_count != '0;
    assign o_item  = r_mem[r_rd_ptr];
    assign do_push = i_push && o_ready;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

endmodule

>>> hw/rtl/drmt_back.sv
// Rectangle engine: damage rectangle, change box, screen registers and result register.
module drmt_back (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_valid,
    input  logic                              i_cfg_index,
    input  logic [drmt_pkg::COORD_BITS-1:0]   i_cfg_data,
    input  logic                              i_q_valid,
    input  drmt_pkg::t_item                   i_q_item,
    output logic                              o_q_pop,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output drmt_pkg::t_result                 o_out
);

    localparam int CB = drmt_pkg::COORD_BITS;
    localparam int PB = drmt_pkg::OUTPOS_BITS;

    logic [CB-1:0] r_scr_w, r_scr_h;
    logic [CB-1:0] r_dmg_x, r_dmg_y, r_dmg_w, r_dmg_h;
    logic [CB-1:0] r_min_x, r_max_x, r_min_y, r_max_y;
    logic          r_seen;
    logic          r_out_valid;
    drmt_pkg::t_result r_out;

    logic [CB-1:0] n_scr_w, n_scr_h;
    logic [CB-1:0] n_dmg_x, n_dmg_y, n_dmg_w, n_dmg_h;
    logic [CB-1:0] n_min_x, n_max_x, n_min_y, n_max_y;
    logic          n_seen;
    logic          n_out_valid;
    drmt_pkg::t_result n_out;

    drmt_pkg::t_item it;
    logic          pop;
    logic          rect_empty;
    logic          rect_live;
    logic [PB-1:0] end_x, end_y;
    logic [CB-1:0] px, py;
    logic [CB-1:0] ux, uy;
    logic [PB-1:0] uend_x, uend_y;
    logic [PB-1:0] uw, uh;
    logic          in_rect;

    assign it         = i_q_item;
    // a screen write takes the cycle, the queued request waits
    assign pop        = i_q_valid && !i_cfg_valid && (!r_out_valid || i_out_ready);
    assign o_q_pop    = pop;
    assign o_out_valid = r_out_valid;
    assign o_out      = r_out;

    assign rect_empty = r_dmg_w == '0 && r_dmg_h == '0;
    assign rect_live  = r_dmg_w != '0 && r_dmg_h != '0;
    assign end_x      = PB'(r_dmg_x) + PB'(r_dmg_w);
    assign end_y      = PB'(r_dmg_y) + PB'(r_dmg_h);
    assign px         = CB'(it.pos_x);
    assign py         = CB'(it.pos_y);

    // union bounding box of the stored rectangle and a report
    assign ux     = (px < r_dmg_x) ? px : r_dmg_x;
    assign uy     = (py < r_dmg_y) ? py : r_dmg_y;
    assign uend_x = (it.rep_end_x > end_x) ? it.rep_end_x : end_x;
    assign uend_y = (it.rep_end_y > end_y) ? it.rep_end_y : end_y;
    assign uw     = uend_x - PB'(ux);
    assign uh     = uend_y - PB'(uy);

    assign in_rect = px >= r_dmg_x && PB'(px) < end_x && py >= r_dmg_y && PB'(py) < end_y;

    always_comb begin
        n_scr_w     = r_scr_w;
        n_scr_h     = r_scr_h;
        n_dmg_x     = r_dmg_x;
        n_dmg_y     = r_dmg_y;
        n_dmg_w     = r_dmg_w;
        n_dmg_h     = r_dmg_h;
        n_min_x     = r_min_x;
        n_max_x     = r_max_x;
        n_min_y     = r_min_y;
        n_max_y     = r_max_y;
        n_seen      = r_seen;
        n_out       = r_out;
        n_out_valid = r_out_valid && !i_out_ready;

        if (i_cfg_valid) begin
            if (i_cfg_index == drmt_pkg::CFG_SCREEN_W) begin
                n_scr_w = i_cfg_data;
            end else begin
                n_scr_h = i_cfg_data;
            end
            // a screen write restarts full-screen damage
            n_dmg_x = '0;
            n_dmg_y = '0;
            n_dmg_w = (i_cfg_index == drmt_pkg::CFG_SCREEN_W) ? i_cfg_data : r_scr_w;
            n_dmg_h = (i_cfg_index == drmt_pkg::CFG_SCREEN_H) ? i_cfg_data : r_scr_h;
            n_min_x = '1;
            n_max_x = '0;
            n_min_y = '1;
            n_max_y = '0;
            n_seen  = 1'b0;
        end else if (pop) begin
            case (it.op)
                drmt_pkg::OP_REPORT: begin
                    if (rect_empty) begin
                        n_dmg_x          = px;
                        n_dmg_y          = py;
                        n_dmg_w          = it.rect_width;
                        n_dmg_h          = it.rect_height;
                        n_out_valid      = 1'b1;
                        n_out.kind       = drmt_pkg::KIND_NOTICE;
                        n_out.out_x      = PB'(it.pos_x);
                        n_out.out_y      = PB'(it.pos_y);
                        n_out.out_width  = it.rect_width;
                        n_out.out_height = it.rect_height;
                    end else begin
                        n_dmg_x = ux;
                        n_dmg_y = uy;
                        n_dmg_w = uw[PB-1] ? '1 : uw[CB-1:0];
                        n_dmg_h = uh[PB-1] ? '1 : uh[CB-1:0];
                    end
                end
                drmt_pkg::OP_PIXEL: begin
                    if (in_rect && it.differ) begin
                        n_min_x = (px < r_min_x) ? px : r_min_x;
                        n_max_x = (px > r_max_x) ? px : r_max_x;
                        n_min_y = (py < r_min_y) ? py : r_min_y;
                        n_max_y = (py > r_max_y) ? py : r_max_y;
                        n_seen  = 1'b1;
                    end
                end
                drmt_pkg::OP_FINISH: begin
                    n_out_valid = 1'b1;
                    n_out.kind  = drmt_pkg::KIND_REFRESH;
                    if (rect_live) begin
                        if (r_seen) begin
                            n_out.out_x      = PB'(r_min_x);
                            n_out.out_y      = PB'(r_min_y);
                            n_out.out_width  = r_max_x - r_min_x + 1'b1;
                            n_out.out_height = r_max_y - r_min_y + 1'b1;
                        end else begin
                            // nothing changed: point just past the damage corner
                            n_out.out_x      = end_x;
                            n_out.out_y      = end_y;
                            n_out.out_width  = '0;
                            n_out.out_height = '0;
                        end
                        n_dmg_w = '0;
                        n_dmg_h = '0;
                        n_min_x = '1;
                        n_max_x = '0;
                        n_min_y = '1;
                        n_max_y = '0;
                        n_seen  = 1'b0;
                    end else begin
                        n_out.out_x      = '0;
                        n_out.out_y      = '0;
                        n_out.out_width  = '0;
                        n_out.out_height = '0;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scr_w     <= drmt_pkg::SCREEN_W_RESET;
            r_scr_h     <= drmt_pkg::SCREEN_H_RESET;
            r_dmg_x     <= '0;
            r_dmg_y     <= '0;
            r_dmg_w     <= drmt_pkg::SCREEN_W_RESET;
            r_dmg_h     <= drmt_pkg::SCREEN_H_RESET;
            r_min_x     <= '1;
            r_max_x     <= '0;
            r_min_y     <= '1;
            r_max_y     <= '0;
            r_seen      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_scr_w     <= n_scr_w;
            r_scr_h     <= n_scr_h;
            r_dmg_x     <= n_dmg_x;
            r_dmg_y     <= n_dmg_y;
            r_dmg_w     <= n_dmg_w;
            r_dmg_h     <= n_dmg_h;
            r_min_x     <= n_min_x;
            r_max_x     <= n_max_x;
            r_min_y     <= n_min_y;
            r_max_y     <= n_max_y;
            r_seen      <= n_seen;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

`ifndef SYNTHESIS
    a_box_ordered: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_seen |-> (r_min_x <= r_max_x && r_min_y <= r_max_y))
        else $error("change box min beyond max");

    a_finish_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (pop && !i_cfg_valid && it.op == drmt_pkg::OP_FINISH && rect_live)
        |=> (r_dmg_w == '0 && r_dmg_h == '0 && !r_seen))
        else $error("finish did not clear damage");

    a_notice_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (pop && !i_cfg_valid && it.op == drmt_pkg::OP_REPORT && rect_empty)
        |=> (r_out_valid && r_out.kind == drmt_pkg::KIND_NOTICE))
        else $error("damage notice missing");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_out_ready) |-> !pop)
        else $error("result register overwritten while stalled");
`endif

endmodule

>>> hw/rtl/damage_rect_merge_and_trim.sv
// Top level of the damage rectangle merge and trim block.
//
// Requests arrive on the s_axis channel: tuser carries the op (damage report,
// pixel pair, finish), tdata the position, report size and the old/new pixels.
// Damage notices and refreshed rectangles leave on the m_axis channel with the
// result kind in tuser. The cfg channel writes screen width (index 0) or
// height (index 1); it is always ready and restarts full-screen damage.
// Throughput is one request per cycle while s_axis_tready is high. A result
// reaches m_axis via the input register, the queue and the result register;
// the engine handles one request per cycle against its state registers unless
// a cfg write or a stalled result holds it. A four-entry queue sits between the
// input stage and the engine, so requests keep being taken while a result waits
// for m_axis_tready; once the queue and the input stage are full, s_axis_tready
// drops until the receiver drains. Synchronous active-low reset empties the
// queue, drops any pending result, sets the screen to 1024 x 768, damage to the
// full screen and clears the change box.
module damage_rect_merge_and_trim (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    // [11:0] pos_x, [23:12] pos_y, [36:24] rect_width, [49:37] rect_height,
    // [81:50] old_pixel, [113:82] new_pixel, [119:114] zero
    input  logic [drmt_pkg::S_TDATA_BITS-1:0]    s_axis_tdata,
    // [1:0] op
    input  logic [drmt_pkg::OP_BITS-1:0]         s_axis_tuser,
    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    // [13:0] out_x, [27:14] out_y, [40:28] out_width, [53:41] out_height,
    // [55:54] zero
    output logic [drmt_pkg::M_TDATA_BITS-1:0]    m_axis_tdata,
    // [0] kind
    output logic                                 m_axis_tuser,
    input  logic                                 i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  logic                                 i_cfg_index,
    input  logic [drmt_pkg::COORD_BITS-1:0]      i_cfg_data
);

    logic              push;
    logic              q_ready;
    logic              q_valid;
    logic              q_pop;
    drmt_pkg::t_item   front_item;
    drmt_pkg::t_item   q_item;
    drmt_pkg::t_result res;

    assign o_cfg_ready = 1'b1;

    drmt_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (s_axis_tvalid),
        .o_ready       (s_axis_tready),
        .i_op          (s_axis_tuser),
        .i_pos_x       (s_axis_tdata[11:0]),
        .i_pos_y       (s_axis_tdata[23:12]),
        .i_rect_width  (s_axis_tdata[36:24]),
        .i_rect_height (s_axis_tdata[49:37]),
        .i_old_pixel   (s_axis_tdata[81:50]),
        .i_new_pixel   (s_axis_tdata[113:82]),
        .o_push        (push),
        .i_q_ready     (q_ready),
        .o_item        (front_item)
    );

    drmt_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .o_ready (q_ready),
        .i_item  (front_item),
        .o_valid (q_valid),
        .i_pop   (q_pop),
        .o_item  (q_item)
    );

    drmt_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_q_valid   (q_valid),
        .i_q_item    (q_item),
        .o_q_pop     (q_pop),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_out       (res)
    );

    assign m_axis_tuser = res.kind;
    assign m_axis_tdata = {2'b00, res.out_height, res.out_width, res.out_y, res.out_x};

endmodule

>>> verif/testbench.sv
// Self-checking testbench for the damage rectangle merge and trim block.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 400000;
    localparam int DRAIN_CYCLES = 20;
    localparam int HOLD_CYCLES = 250;

    typedef struct {
        logic [drmt_pkg::OP_BITS-1:0]     op;
        logic [drmt_pkg::IN_POS_BITS-1:0] px;
        logic [drmt_pkg::IN_POS_BITS-1:0] py;
        logic [drmt_pkg::COORD_BITS-1:0]  rw;
        logic [drmt_pkg::COORD_BITS-1:0]  rh;
        logic [drmt_pkg::PIXEL_BITS-1:0]  old_pix;
        logic [drmt_pkg::PIXEL_BITS-1:0]  new_pix;
    } t_req;

    logic                              i_clk = 1'b0;
    logic                              i_rst_n = 1'b0;
    logic                              s_axis_tvalid = 1'b0;
    logic                              s_axis_tready;
    logic [drmt_pkg::S_TDATA_BITS-1:0] s_axis_tdata = '0;
    logic [drmt_pkg::OP_BITS-1:0]      s_axis_tuser = '0;
    logic                              m_axis_tvalid;
    logic                              m_axis_tready = 1'b0;
    logic [drmt_pkg::M_TDATA_BITS-1:0] m_axis_tdata;
    logic                              m_axis_tuser;
    logic                              i_cfg_valid = 1'b0;
    logic                              o_cfg_ready;
    logic                              i_cfg_index = 1'b0;
    logic [drmt_pkg::COORD_BITS-1:0]   i_cfg_data = '0;

    damage_rect_merge_and_trim dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    t_req              pending_reqs[$];
    drmt_pkg::t_result expected_rects[$];
    t_req              cur_req;
    int            tx_idle_pct = 0;
    int            rx_stall_pct = 0;
    int            errors = 0;
    int            reqs_accepted = 0;
    int            rects_checked = 0;
    int            cfg_writes = 0;
    int            cycle_count = 0;
    int            hold_left = 0;
    logic          hold_arm = 1'b0;
    logic          hold_used = 1'b0;

    // Shadow of the block's screen size, damage rectangle and change box
    logic [drmt_pkg::COORD_BITS-1:0] scr_w, scr_h;
    logic [drmt_pkg::COORD_BITS-1:0] dmg_x, dmg_y, dmg_w, dmg_h;
    logic [drmt_pkg::COORD_BITS-1:0] chg_min_x, chg_max_x, chg_min_y, chg_max_y;
    logic                            chg_seen;

    task automatic clear_change_box();
        chg_min_x = '1;
        chg_max_x = '0;
        chg_min_y = '1;
        chg_max_y = '0;
        chg_seen = 1'b0;
    endtask

    task automatic restart_full_screen();
        dmg_x = '0;
        dmg_y = '0;
        dmg_w = scr_w;
        dmg_h = scr_h;
        clear_change_box();
    endtask

    task automatic push_rect(logic kind, int x, int y, int w, int h);
        drmt_pkg::t_result r;
        r.kind = kind;
        r.out_x = drmt_pkg::OUTPOS_BITS'(x);
        r.out_y = drmt_pkg::OUTPOS_BITS'(y);
        r.out_width = drmt_pkg::COORD_BITS'(w);
        r.out_height = drmt_pkg::COORD_BITS'(h);
        expected_rects.push_back(r);
    endtask

    // Advance the shadow state by one request and queue the rectangle it yields
    task automatic track_damage(t_req r);
        int end_x, end_y, span_x, span_y;
        logic hit;
        case (r.op)
            drmt_pkg::OP_REPORT: begin
                if (dmg_w == 0 && dmg_h == 0) begin
                    dmg_x = drmt_pkg::COORD_BITS'(r.px);
                    dmg_y = drmt_pkg::COORD_BITS'(r.py);
                    dmg_w = r.rw;
                    dmg_h = r.rh;
                    push_rect(drmt_pkg::KIND_NOTICE, int'(dmg_x), int'(dmg_y),
                              int'(dmg_w), int'(dmg_h));
                end else begin
                    end_x = int'(dmg_x) + int'(dmg_w);
                    end_y = int'(dmg_y) + int'(dmg_h);
                    if (r.px < dmg_x) dmg_x = drmt_pkg::COORD_BITS'(r.px);
                    if (r.py < dmg_y) dmg_y = drmt_pkg::COORD_BITS'(r.py);
                    if (int'(r.px) + int'(r.rw) > end_x) end_x = int'(r.px) + int'(r.rw);
                    if (int'(r.py) + int'(r.rh) > end_y) end_y = int'(r.py) + int'(r.rh);
                    span_x = end_x - int'(dmg_x);
                    span_y = end_y - int'(dmg_y);
                    // union wider than the coordinate field saturates
                    dmg_w = (span_x > 8191) ? '1 : drmt_pkg::COORD_BITS'(span_x);
                    dmg_h = (span_y > 8191) ? '1 : drmt_pkg::COORD_BITS'(span_y);
                end
            end
            drmt_pkg::OP_PIXEL: begin
                hit = r.px >= dmg_x && int'(r.px) < int'(dmg_x) + int'(dmg_w) &&
                      r.py >= dmg_y && int'(r.py) < int'(dmg_y) + int'(dmg_h);
                if (hit && r.old_pix != r.new_pix) begin
                    if (r.px < chg_min_x) chg_min_x = drmt_pkg::COORD_BITS'(r.px);
                    if (r.px > chg_max_x) chg_max_x = drmt_pkg::COORD_BITS'(r.px);
                    if (r.py < chg_min_y) chg_min_y = drmt_pkg::COORD_BITS'(r.py);
                    if (r.py > chg_max_y) chg_max_y = drmt_pkg::COORD_BITS'(r.py);
                    chg_seen = 1'b1;
                end
            end
            drmt_pkg::OP_FINISH: begin
                if (dmg_w != 0 && dmg_h != 0) begin
                    if (chg_seen)
                        push_rect(drmt_pkg::KIND_REFRESH, int'(chg_min_x), int'(chg_min_y),
                                  int'(chg_max_x) - int'(chg_min_x) + 1,
                                  int'(chg_max_y) - int'(chg_min_y) + 1);
                    else
                        push_rect(drmt_pkg::KIND_REFRESH, int'(dmg_x) + int'(dmg_w),
                                  int'(dmg_y) + int'(dmg_h), 0, 0);
                    dmg_w = '0;
                    dmg_h = '0;
                    clear_change_box();
                end else begin
                    push_rect(drmt_pkg::KIND_REFRESH, 0, 0, 0, 0);
                end
            end
            default: ;
        endcase
    endtask

    task automatic check_field(string name, int want, int got);
        if (want != got) begin
            $error("%s mismatch: expected %0d, got %0d", name, want, got);
            errors++;
        end
    endtask

    // Request driver
    always @(posedge i_clk) begin
        logic holding;
        holding = s_axis_tvalid && !s_axis_tready;
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                track_damage(cur_req);
                reqs_accepted++;
            end
            if (!holding) begin
                if (pending_reqs.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
                    cur_req = pending_reqs.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata <= {6'b0, cur_req.new_pix, cur_req.old_pix, cur_req.rh,
                                     cur_req.rw, cur_req.py, cur_req.px};
                    s_axis_tuser <= cur_req.op;
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // Long receiver hold-off, fired once
    always @(posedge i_clk) begin
        if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end else if (i_rst_n && hold_arm && !hold_used) begin
            hold_left <= HOLD_CYCLES;
            hold_used <= 1'b1;
        end
    end

    // Result monitor
    always @(posedge i_clk) begin
        drmt_pkg::t_result want;
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (expected_rects.size() == 0) begin
                    $error("unexpected result: kind %0d tdata %h", m_axis_tuser, m_axis_tdata);
                    errors++;
                end else begin
                    want = expected_rects.pop_front();
                    check_field("kind", int'(want.kind), int'(m_axis_tuser));
                    check_field("out_x", int'(want.out_x), int'(m_axis_tdata[13:0]));
                    check_field("out_y", int'(want.out_y), int'(m_axis_tdata[27:14]));
                    check_field("out_width", int'(want.out_width),
                                int'(m_axis_tdata[40:28]));
                    check_field("out_height", int'(want.out_height),
                                int'(m_axis_tdata[53:41]));
                    rects_checked++;
                end
            end
            m_axis_tready <= (hold_left == 0) && ($urandom_range(99) >= rx_stall_pct);
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("damage_rect_merge_and_trim test failed");
            $finish;
        end
    end

    task automatic push_req(logic [drmt_pkg::OP_BITS-1:0] op, int px, int py, int rw, int rh,
                            logic [drmt_pkg::PIXEL_BITS-1:0] old_pix,
                            logic [drmt_pkg::PIXEL_BITS-1:0] new_pix);
        t_req r;
        r.op = op;
        r.px = drmt_pkg::IN_POS_BITS'(px);
        r.py = drmt_pkg::IN_POS_BITS'(py);
        r.rw = drmt_pkg::COORD_BITS'(rw);
        r.rh = drmt_pkg::COORD_BITS'(rh);
        r.old_pix = old_pix;
        r.new_pix = new_pix;
        pending_reqs.push_back(r);
    endtask

    // One refresh cycle: one to three reports, two to twelve pixel pairs around the first one, finish
    task automatic add_frame(int sw, int sh, inout int count);
        int lim_x, lim_y, x0, y0, w0, h0, x, y, w, h, n_rep, n_pix, px, py;
        logic [drmt_pkg::PIXEL_BITS-1:0] old_pix, new_pix;
        lim_x = (sw < 1) ? 1 : (sw > 4096) ? 4096 : sw;
        lim_y = (sh < 1) ? 1 : (sh > 4096) ? 4096 : sh;
        n_rep = $urandom_range(1, 3);
        for (int i = 0; i < n_rep; i++) begin
            x = $urandom_range(0, lim_x - 1);
            y = $urandom_range(0, lim_y - 1);
            w = ($urandom_range(3) == 0) ? $urandom_range(0, lim_x - x)
                                         : $urandom_range(0, (lim_x - x < 16) ? lim_x - x : 16);
            h = ($urandom_range(3) == 0) ? $urandom_range(0, lim_y - y)
                                         : $urandom_range(0, (lim_y - y < 16) ? lim_y - y : 16);
            if (i == 0) begin
                x0 = x; y0 = y; w0 = w; h0 = h;
            end
            push_req(drmt_pkg::OP_REPORT, x, y, w, h, $urandom, $urandom);
        end
        n_pix = $urandom_range(2, 12);
        for (int i = 0; i < n_pix; i++) begin
            px = x0 + $urandom_range(0, w0);
            py = y0 + $urandom_range(0, h0);
            if (px > 4095) px = 4095;
            if (py > 4095) py = 4095;
            old_pix = $urandom;
            case ($urandom_range(2))
                0: new_pix = old_pix;
                1: new_pix = old_pix ^ (32'd1 << $urandom_range(31));
                default: new_pix = $urandom;
            endcase
            push_req(drmt_pkg::OP_PIXEL, px, py, $urandom, $urandom, old_pix, new_pix);
        end
        push_req(drmt_pkg::OP_FINISH, $urandom, $urandom, $urandom, $urandom, $urandom,
                 $urandom);
        count += n_rep + n_pix + 1;
    endtask

    task automatic add_random(int n);
        int count;
        logic [drmt_pkg::OP_BITS-1:0] op;
        count = 0;
        while (count < n) begin
            if ($urandom_range(99) < 80) begin
                add_frame(int'(scr_w), int'(scr_h), count);
            end else begin
                op = drmt_pkg::OP_BITS'($urandom_range(0, 3));
                push_req(op, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
                if (op != drmt_pkg::OP_NONE) count++;
            end
        end
    endtask

    task automatic wait_idle();
        do @(negedge i_clk);
        while (pending_reqs.size() != 0 || s_axis_tvalid || expected_rects.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_screen(logic idx, int value);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= drmt_pkg::COORD_BITS'(value);
        do @(posedge i_clk);
        while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        if (idx == drmt_pkg::CFG_SCREEN_W) scr_w = drmt_pkg::COORD_BITS'(value);
        else scr_h = drmt_pkg::COORD_BITS'(value);
        restart_full_screen();
        cfg_writes++;
    endtask

    task automatic run_phase(int w, int h, int tx_pct, int rx_pct, int n);
        write_screen(drmt_pkg::CFG_SCREEN_W, w);
        write_screen(drmt_pkg::CFG_SCREEN_H, h);
        tx_idle_pct = tx_pct;
        rx_stall_pct = rx_pct;
        add_random(n);
        wait_idle();
    endtask

    initial begin
        scr_w = drmt_pkg::SCREEN_W_RESET;
        scr_h = drmt_pkg::SCREEN_H_RESET;
        restart_full_screen();

        // Directed part against the reset screen of 1024 x 768
        push_req(drmt_pkg::OP_PIXEL, 0, 0, 0, 0, 32'h0, 32'hffff_ffff);
        push_req(drmt_pkg::OP_PIXEL, 1023, 767, 0, 0, 32'h1, 32'h1);
        push_req(drmt_pkg::OP_PIXEL, 1024, 0, 0, 0, 32'h0, 32'h5);   // just right of the edge
        push_req(drmt_pkg::OP_PIXEL, 1023, 767, 0, 0, 32'h0, 32'h1);
        push_req(drmt_pkg::OP_NONE, 4095, 4095, 8191, 8191, '1, '1);
        push_req(drmt_pkg::OP_FINISH, 0, 0, 0, 0, 0, 0);
        // nothing left: empty rect
        push_req(drmt_pkg::OP_FINISH, 4095, 4095, 8191, 8191, '1, '0);
        push_req(drmt_pkg::OP_REPORT, 5, 7, 0, 0, 0, 0);            // zero-size report into empty
        push_req(drmt_pkg::OP_REPORT, 100, 200, 50, 60, 0, 0);
        push_req(drmt_pkg::OP_REPORT, 4095, 4095, 8191, 8191, 0, 0); // union saturates
        push_req(drmt_pkg::OP_PIXEL, 4095, 4095, 0, 0, 32'hffff_ffff, 32'h0);
        push_req(drmt_pkg::OP_FINISH, 0, 0, 0, 0, 0, 0);
        push_req(drmt_pkg::OP_REPORT, 10, 20, 4096, 4096, 0, 0);
        push_req(drmt_pkg::OP_FINISH, 0, 0, 0, 0, 0, 0);            // no change seen
        push_req(drmt_pkg::OP_REPORT, 0, 0, 0, 5, 0, 0);
        push_req(drmt_pkg::OP_PIXEL, 0, 1, 0, 0, 32'h0, 32'h1);
        push_req(drmt_pkg::OP_FINISH, 0, 0, 0, 0, 0, 0);            // zero width: empty rect
        push_req(drmt_pkg::OP_REPORT, 3, 3, 2, 2, 0, 0);
        push_req(drmt_pkg::OP_PIXEL, 4, 4, 0, 0, 32'h7, 32'h7);
        push_req(drmt_pkg::OP_FINISH, 0, 0, 0, 0, 0, 0);
        add_random(130);
        hold_arm = 1'b1;

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        wait_idle();

        run_phase(1, 1, 61, 0, 100);
        run_phase(4096, 4096, 0, 61, 150);
        run_phase(8191, 0, 14, 14, 100);
        run_phase(0, 8191, 0, 0, 100);
        run_phase(640, 480, 14, 14, 200);

        $display("%0d requests and %0d screen writes, %0d rectangles checked",
                 reqs_accepted, cfg_writes, rects_checked);
        $display("screens from 0 to 8191 wide, with idle, stall and hold-off on both sides");
        if (errors == 0) begin
            $display("damage_rect_merge_and_trim test passed");
        end else begin
            $display("damage_rect_merge_and_trim test failed");
        end
        $finish;
    end

endmodule
